// ===== rtl/utf8_to_code_point_decoder_core_macros.svh =====
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef UTF8_TO_CODE_POINT_DECODER_CORE_MACROS_SVH
`define UTF8_TO_CODE_POINT_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define U2CP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U2CP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/u2cp_pkg.sv =====
package u2cp_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int NEED_W = 2;
	localparam int CONT_BITS = 6;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [NEED_W-1:0] need_t;

	// continuation byte 10xxxxxx
	localparam byte_t CONT_MASK  = 8'hC0;
	localparam byte_t CONT_TAG   = 8'h80;
	localparam byte_t CONT_PAY   = 8'h3F;
	// single byte 0xxxxxxx
	localparam byte_t ASCII_MASK = 8'h80;
	localparam byte_t ASCII_TAG  = 8'h00;
	// two byte lead 110xxxxx
	localparam byte_t LEAD2_MASK = 8'hE0;
	localparam byte_t LEAD2_TAG  = 8'hC0;
	localparam byte_t LEAD2_PAY  = 8'h1F;
	// three byte lead 1110xxxx
	localparam byte_t LEAD3_MASK = 8'hF0;
	localparam byte_t LEAD3_TAG  = 8'hE0;
	localparam byte_t LEAD3_PAY  = 8'h0F;
	// four byte lead 11110xxx
	localparam byte_t LEAD4_MASK = 8'hF8;
	localparam byte_t LEAD4_TAG  = 8'hF0;
	localparam byte_t LEAD4_PAY  = 8'h07;

	localparam byte_t END_BYTE = 8'h00;

	localparam need_t NEED_NONE  = 2'd0;
	localparam need_t NEED_ONE   = 2'd1;
	localparam need_t NEED_TWO   = 2'd2;
	localparam need_t NEED_THREE = 2'd3;

	typedef struct packed {
		logic  emit;
		cp_t   code;
		need_t need_nxt;
		cp_t   part_nxt;
	} step_t;

endpackage

// ===== rtl/u2cp_step.sv =====
module u2cp_step
	import u2cp_pkg::*;
(
	input  byte_t in_byte,
	input  need_t need,
	input  cp_t   part,
	output step_t res
);

	cp_t shifted;

	assign shifted = {part[CP_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};

	always_comb begin
		res = '0;
		if (need != NEED_NONE && (in_byte & CONT_MASK) == CONT_TAG) begin
			if (need == NEED_ONE) begin
				res.emit = 1'b1;
				res.code = shifted;
			end else begin
				res.need_nxt = need - NEED_ONE;
				res.part_nxt = shifted;
			end
		end else if (in_byte == END_BYTE) begin
			// end of string, pending sequence dropped
		end else if ((in_byte & ASCII_MASK) == ASCII_TAG) begin
			res.emit = 1'b1;
			res.code = {{(CP_W-BYTE_W){1'b0}}, in_byte};
		end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
			res.need_nxt = NEED_ONE;
			res.part_nxt = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD2_PAY};
		end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
			res.need_nxt = NEED_TWO;
			res.part_nxt = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD3_PAY};
		end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
			res.need_nxt = NEED_THREE;
			res.part_nxt = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD4_PAY};
		end
		// stray continuation or 0xf8..0xff: skipped, nothing pending
	end

endmodule

// ===== rtl/utf8_to_code_point_decoder_core.sv =====
// channel | handshake                   | word
// --------+-----------------------------+-------------------------
// source  | src_valid / src_stall       | in_byte, 8 bit raw byte
// result  | dst_valid / dst_stall       | code_point, 21 bit value
//
// one byte is taken per cycle while src_stall is low; the byte that
// completes a code point passes the input register and then the result register
// the decode itself is one short step through u2cp_step between them
// arst_n clears the sequence state and both valid flags at once
// a stalled result holds the input register only when both stages are full
module utf8_to_code_point_decoder_core
	import u2cp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  src_valid,
	output logic  src_stall,
	input  byte_t in_byte,
	output logic  dst_valid,
	input  logic  dst_stall,
	output cp_t   code_point
);

	// input register
	logic  valid_s1;
	byte_t byte_s1;

	// sequence state: continuation bytes still due and bits gathered so far
	need_t need_q;
	cp_t   part_q;

	// result register
	logic  valid_s2;
	cp_t   cp_s2;

	step_t step;
	logic  adv;

	u2cp_step u_step (
		.in_byte (byte_s1),
		.need    (need_q),
		.part    (part_q),
		.res     (step)
	);

	// the result register is free when empty or being drained this cycle
	assign adv       = !valid_s2 || !dst_stall;
	// only stall when the held byte cannot move on
	assign src_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			need_q   <= NEED_NONE;
			part_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			// input register loads whenever it is not stalled
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
			// sequence state moves with each decoded byte
			if (adv && valid_s1) begin
				need_q <= step.need_nxt;
				part_q <= step.part_nxt;
			end
			if (adv) begin
				valid_s2 <= valid_s1 && step.emit;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			byte_s1 <= in_byte;
		end
		if (adv && valid_s1 && step.emit) begin
			cp_s2 <= step.code;
		end
	end

	assign dst_valid  = valid_s2;
	assign code_point = cp_s2;

endmodule

// ===== rtl/u2cp_checker.sv =====
`include "utf8_to_code_point_decoder_core_macros.svh"

module u2cp_checker
	import u2cp_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  src_valid,
	input logic  src_stall,
	input byte_t in_byte,
	input logic  dst_valid,
	input logic  dst_stall,
	input cp_t   code_point
);

	logic src_acc;
	logic dst_free;
	logic ascii_acc;

	assign src_acc   = src_valid && !src_stall;
	assign dst_free  = !dst_valid || !dst_stall;
	assign ascii_acc = src_acc && in_byte != END_BYTE && (in_byte & ASCII_MASK) == ASCII_TAG;

	// input held back only behind a full, stalled result
	`U2CP_ASSERT_IMP(a_stall_cause, src_stall, dst_valid && dst_stall, "input stalled with result free")

	// a fresh result needs a byte taken earlier, or one held back by a stall, ahead of the input and result registers
	`U2CP_ASSERT_IMP(a_no_invent, dst_valid && !$past(dst_valid && dst_stall), $past(src_acc || src_stall, 2), "result without a byte behind it")

	// a single byte character comes straight out unless the result side was blocked
	`U2CP_ASSERT_NXT(a_ascii_pass, ascii_acc ##1 dst_free, dst_valid && code_point == {{(CP_W-BYTE_W){1'b0}}, $past(in_byte, 2)}, "single byte character lost")

	// stalled result holds
	`U2CP_ASSERT_NXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(code_point), "stalled result changed")

endmodule

bind utf8_to_code_point_decoder_core u2cp_checker u_chk (.*);
